@@ design/smbus_wm_pkg.sv @@
// Shared bus action codes, phase codes and field widths of the SMBus word master sequencer.
package smbus_wm_pkg;

  // Bus action requested from the bit-level engine
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_START  = 3'd1,
    ACT_TX     = 3'd2,
    ACT_RSTART = 3'd3,
    ACT_RECV   = 3'd4,
    ACT_ACK    = 3'd5,
    ACT_NACK   = 3'd6,
    ACT_STOP   = 3'd7
  } bus_action_e;

  // Input kinds carried on tuser
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  // Phase counter width and codes
  localparam int unsigned PhaseW = 4;
  localparam logic [PhaseW-1:0] PH_0          = 4'd0;
  localparam logic [PhaseW-1:0] PH_1          = 4'd1;
  localparam logic [PhaseW-1:0] PH_2          = 4'd2;
  localparam logic [PhaseW-1:0] PH_3          = 4'd3;
  localparam logic [PhaseW-1:0] PH_4          = 4'd4;
  localparam logic [PhaseW-1:0] PH_5          = 4'd5;
  localparam logic [PhaseW-1:0] PH_6          = 4'd6;
  localparam logic [PhaseW-1:0] PH_7          = 4'd7;
  localparam logic [PhaseW-1:0] PH_8          = 4'd8;
  localparam logic [PhaseW-1:0] PH_READ_DONE  = 4'd9;
  localparam logic [PhaseW-1:0] PH_WRITE_DONE = 4'd5;
  localparam logic [PhaseW-1:0] PH_IDLE       = 4'd10;

  // Stream widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;

endpackage

@@ design/smbus_word_master_sequencer.sv @@
// Top level of the SMBus Read Word / Write Word master sequencer.
//
// Usage:
//   The slave stream carries one item per transaction. tuser = 0 begins a
//   new word transaction (direction, address, command and write bytes on
//   tdata); tuser = 1 reports that the previous bus step completed, with the
//   received byte on tdata for the capture steps. Every item yields exactly
//   one result on the master stream: the next bus action, the byte to send,
//   both done flags and the received word.
//   The result is registered and valid in the cycle after the item is accepted.
//   Throughput: one item per cycle unless the receiver stalls; the whole
//   phase update is a single level of logic between state and result registers.
//   A begin while a transaction runs restarts it from the start condition.
//   Reset puts the phase at idle and clears the latched operands, received
//   bytes and done flags; the result register comes up empty.
//   When the receiver stalls, the result register holds its transaction and
//   s_axis_tready drops; it stays high as long as the result is taken.
module smbus_word_master_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // is_read[0], slave_address[7:1], command_code[15:8], write_low[23:16],
  // write_high[31:24], rx_byte[39:32]
  input  logic [smbus_wm_pkg::InDataW-1:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bus_action[2:0], tx_byte[10:3], read_done[11], write_done[12],
  // read_word[28:13], zero[31:29]
  output logic [smbus_wm_pkg::OutDataW-1:0] m_axis_tdata
);

  // Unpack the input item
  logic       in_is_read;
  logic [6:0] in_addr;
  logic [7:0] in_cmd;
  logic [7:0] in_wlow;
  logic [7:0] in_whigh;
  logic [7:0] in_rx;

  assign in_is_read = s_axis_tdata[0];
  assign in_addr    = s_axis_tdata[7:1];
  assign in_cmd     = s_axis_tdata[15:8];
  assign in_wlow    = s_axis_tdata[23:16];
  assign in_whigh   = s_axis_tdata[31:24];
  assign in_rx      = s_axis_tdata[39:32];

  // Sequencer state
  logic [smbus_wm_pkg::PhaseW-1:0] phase_q, phase_d;
  logic       read_mode_q, read_mode_d;
  logic [6:0] addr_q, addr_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] out_low_q, out_low_d;
  logic [7:0] out_high_q, out_high_d;
  logic [7:0] got_low_q, got_low_d;
  logic [7:0] got_high_q, got_high_d;
  logic       rd_done_q, rd_done_d;
  logic       wr_done_q, wr_done_d;

  // Result register
  logic                                m_valid_q;
  logic [smbus_wm_pkg::OutDataW-1:0]   m_data_q, m_data_d;

  smbus_wm_pkg::bus_action_e act;
  logic [7:0] tx;
  logic       accept;

  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Work out the next phase and the bus action for one item
  always_comb begin
    phase_d     = phase_q;
    read_mode_d = read_mode_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    out_low_d   = out_low_q;
    out_high_d  = out_high_q;
    got_low_d   = got_low_q;
    got_high_d  = got_high_q;
    rd_done_d   = rd_done_q;
    wr_done_d   = wr_done_q;
    act         = smbus_wm_pkg::ACT_NONE;
    tx          = 8'h00;

    if (s_axis_tuser == smbus_wm_pkg::OP_BEGIN) begin
      // Latch the operands and request a start
      read_mode_d = in_is_read;
      addr_d      = in_addr;
      cmd_d       = in_cmd;
      out_low_d   = in_wlow;
      out_high_d  = in_whigh;
      rd_done_d   = 1'b0;
      wr_done_d   = 1'b0;
      phase_d     = smbus_wm_pkg::PH_0;
      act         = smbus_wm_pkg::ACT_START;
    end else if (read_mode_q) begin
      // Read word sequence
      case (phase_q)
        smbus_wm_pkg::PH_0: begin
          act = smbus_wm_pkg::ACT_TX; tx = {addr_q, 1'b0}; phase_d = smbus_wm_pkg::PH_1;
        end
        smbus_wm_pkg::PH_1: begin
          act = smbus_wm_pkg::ACT_TX; tx = cmd_q; phase_d = smbus_wm_pkg::PH_2;
        end
        smbus_wm_pkg::PH_2: begin
          act = smbus_wm_pkg::ACT_RSTART; phase_d = smbus_wm_pkg::PH_3;
        end
        smbus_wm_pkg::PH_3: begin
          act = smbus_wm_pkg::ACT_TX; tx = {addr_q, 1'b1}; phase_d = smbus_wm_pkg::PH_4;
        end
        smbus_wm_pkg::PH_4: begin
          act = smbus_wm_pkg::ACT_RECV; phase_d = smbus_wm_pkg::PH_5;
        end
        smbus_wm_pkg::PH_5: begin
          got_low_d = in_rx; act = smbus_wm_pkg::ACT_ACK; phase_d = smbus_wm_pkg::PH_6;
        end
        smbus_wm_pkg::PH_6: begin
          act = smbus_wm_pkg::ACT_RECV; phase_d = smbus_wm_pkg::PH_7;
        end
        smbus_wm_pkg::PH_7: begin
          got_high_d = in_rx; act = smbus_wm_pkg::ACT_NACK; phase_d = smbus_wm_pkg::PH_8;
        end
        smbus_wm_pkg::PH_8: begin
          act = smbus_wm_pkg::ACT_STOP; phase_d = smbus_wm_pkg::PH_READ_DONE;
        end
        smbus_wm_pkg::PH_READ_DONE: begin
          rd_done_d = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      // Write word sequence
      case (phase_q)
        smbus_wm_pkg::PH_0: begin
          act = smbus_wm_pkg::ACT_TX; tx = {addr_q, 1'b0}; phase_d = smbus_wm_pkg::PH_1;
        end
        smbus_wm_pkg::PH_1: begin
          act = smbus_wm_pkg::ACT_TX; tx = cmd_q; phase_d = smbus_wm_pkg::PH_2;
        end
        smbus_wm_pkg::PH_2: begin
          act = smbus_wm_pkg::ACT_TX; tx = out_low_q; phase_d = smbus_wm_pkg::PH_3;
        end
        smbus_wm_pkg::PH_3: begin
          act = smbus_wm_pkg::ACT_TX; tx = out_high_q; phase_d = smbus_wm_pkg::PH_4;
        end
        smbus_wm_pkg::PH_4: begin
          act = smbus_wm_pkg::ACT_STOP; phase_d = smbus_wm_pkg::PH_WRITE_DONE;
        end
        smbus_wm_pkg::PH_WRITE_DONE: begin
          wr_done_d = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Pack the result transaction
    m_data_d = {3'b000, got_high_d, got_low_d, wr_done_d, rd_done_d, tx, act};
  end

  // Advance state on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= smbus_wm_pkg::PH_IDLE;
      read_mode_q <= 1'b0;
      addr_q      <= 7'd0;
      cmd_q       <= 8'd0;
      out_low_q   <= 8'd0;
      out_high_q  <= 8'd0;
      got_low_q   <= 8'd0;
      got_high_q  <= 8'd0;
      rd_done_q   <= 1'b0;
      wr_done_q   <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      read_mode_q <= read_mode_d;
      addr_q      <= addr_d;
      cmd_q       <= cmd_d;
      out_low_q   <= out_low_d;
      out_high_q  <= out_high_d;
      got_low_q   <= got_low_d;
      got_high_q  <= got_high_d;
      rd_done_q   <= rd_done_d;
      wr_done_q   <= wr_done_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= m_data_d;
    end
  end

endmodule

@@ tb/smbus_wm_checker.sv @@
// Checker that predicts and compares every result of the SMBus word master sequencer.
`timescale 1ns / 100ps
module smbus_wm_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  // is_read[0], slave_address[7:1], command_code[15:8], write_low[23:16],
  // write_high[31:24], rx_byte[39:32]
  input  logic [smbus_wm_pkg::InDataW-1:0]  in_data_i,
  // opcode[0]
  input  logic                              in_user_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  // bus_action[2:0], tx_byte[10:3], read_done[11], write_done[12],
  // read_word[28:13], zero[31:29]
  input  logic [smbus_wm_pkg::OutDataW-1:0] out_data_i,
  output int                                mismatches_o,
  output int                                outstanding_o
);

  // One bus step as the sequencer reports it, highest field first
  typedef struct packed {
    logic [2:0]                precede_pad;
    logic [15:0]               word;
    logic                      wr_done;
    logic                      rd_done;
    logic [7:0]                tx;
    smbus_wm_pkg::bus_action_e act;
  } bus_step_t;

  // Shadow copy of the sequencer state
  logic [smbus_wm_pkg::PhaseW-1:0] phase_q;
  logic              rd_mode_q;
  logic [6:0]        addr_q;
  logic [7:0]        cmd_q;
  logic [7:0]        wr_lo_q;
  logic [7:0]        wr_hi_q;
  logic [7:0]        got_lo_q;
  logic [7:0]        got_hi_q;
  logic              rd_cmp_q;
  logic              wr_cmp_q;

  int mismatch_cnt = 0;
  int outstanding_cnt = 0;

  bus_step_t bus_step_q[$];

  assign mismatches_o  = mismatch_cnt;
  assign outstanding_o = outstanding_cnt;

  // Advance the shadow state by one item and return the bus step it causes
  task automatic predict_bus_step(input logic op,
                                  input logic [smbus_wm_pkg::InDataW-1:0] d,
                                  output bus_step_t r);
    logic [7:0] rx;
    rx = d[39:32];
    r = '0;
    r.act = smbus_wm_pkg::ACT_NONE;
    if (op == smbus_wm_pkg::OP_BEGIN) begin
      rd_mode_q = d[0];
      addr_q    = d[7:1];
      cmd_q     = d[15:8];
      wr_lo_q   = d[23:16];
      wr_hi_q   = d[31:24];
      rd_cmp_q  = 1'b0;
      wr_cmp_q  = 1'b0;
      phase_q   = smbus_wm_pkg::PH_0;
      r.act     = smbus_wm_pkg::ACT_START;
    end else if (rd_mode_q) begin
      case (phase_q)
        smbus_wm_pkg::PH_0: begin
          r.act = smbus_wm_pkg::ACT_TX; r.tx = {addr_q, 1'b0}; phase_q = smbus_wm_pkg::PH_1;
        end
        smbus_wm_pkg::PH_1: begin
          r.act = smbus_wm_pkg::ACT_TX; r.tx = cmd_q; phase_q = smbus_wm_pkg::PH_2;
        end
        smbus_wm_pkg::PH_2: begin
          r.act = smbus_wm_pkg::ACT_RSTART; phase_q = smbus_wm_pkg::PH_3;
        end
        smbus_wm_pkg::PH_3: begin
          r.act = smbus_wm_pkg::ACT_TX; r.tx = {addr_q, 1'b1}; phase_q = smbus_wm_pkg::PH_4;
        end
        smbus_wm_pkg::PH_4: begin
          r.act = smbus_wm_pkg::ACT_RECV; phase_q = smbus_wm_pkg::PH_5;
        end
        smbus_wm_pkg::PH_5: begin
          got_lo_q = rx; r.act = smbus_wm_pkg::ACT_ACK; phase_q = smbus_wm_pkg::PH_6;
        end
        smbus_wm_pkg::PH_6: begin
          r.act = smbus_wm_pkg::ACT_RECV; phase_q = smbus_wm_pkg::PH_7;
        end
        smbus_wm_pkg::PH_7: begin
          got_hi_q = rx; r.act = smbus_wm_pkg::ACT_NACK; phase_q = smbus_wm_pkg::PH_8;
        end
        smbus_wm_pkg::PH_8: begin
          r.act = smbus_wm_pkg::ACT_STOP; phase_q = smbus_wm_pkg::PH_READ_DONE;
        end
        smbus_wm_pkg::PH_READ_DONE: begin
          rd_cmp_q = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      case (phase_q)
        smbus_wm_pkg::PH_0: begin
          r.act = smbus_wm_pkg::ACT_TX; r.tx = {addr_q, 1'b0}; phase_q = smbus_wm_pkg::PH_1;
        end
        smbus_wm_pkg::PH_1: begin
          r.act = smbus_wm_pkg::ACT_TX; r.tx = cmd_q; phase_q = smbus_wm_pkg::PH_2;
        end
        smbus_wm_pkg::PH_2: begin
          r.act = smbus_wm_pkg::ACT_TX; r.tx = wr_lo_q; phase_q = smbus_wm_pkg::PH_3;
        end
        smbus_wm_pkg::PH_3: begin
          r.act = smbus_wm_pkg::ACT_TX; r.tx = wr_hi_q; phase_q = smbus_wm_pkg::PH_4;
        end
        smbus_wm_pkg::PH_4: begin
          r.act = smbus_wm_pkg::ACT_STOP; phase_q = smbus_wm_pkg::PH_WRITE_DONE;
        end
        smbus_wm_pkg::PH_WRITE_DONE: begin
          wr_cmp_q = 1'b1;
        end
        default: begin
        end
      endcase
    end
    r.rd_done = rd_cmp_q;
    r.wr_done = wr_cmp_q;
    r.word    = {got_hi_q, got_lo_q};
  endtask

  // Count a field mismatch; report only the first few
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endtask

  // Compare each result transaction, then predict each input transaction
  always @(posedge clk_i or negedge rst_ni) begin : watch
    bus_step_t want;
    bus_step_t got;
    if (!rst_ni) begin
      phase_q   = smbus_wm_pkg::PH_IDLE;
      rd_mode_q = 1'b0;
      addr_q    = '0;
      cmd_q     = '0;
      wr_lo_q   = '0;
      wr_hi_q   = '0;
      got_lo_q  = '0;
      got_hi_q  = '0;
      rd_cmp_q  = 1'b0;
      wr_cmp_q  = 1'b0;
      bus_step_q.delete();
      outstanding_cnt = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (bus_step_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result 0x%0h with no bus step pending", $realtime, out_data_i);
        end else begin
          want = bus_step_q.pop_front();
          check_field("bus_action", 16'(want.act), 16'(got.act));
          check_field("tx_byte", 16'(want.tx), 16'(got.tx));
          check_field("read_done", 16'(want.rd_done), 16'(got.rd_done));
          check_field("write_done", 16'(want.wr_done), 16'(got.wr_done));
          check_field("read_word", want.word, got.word);
          check_field("zero pad", 16'(want.precede_pad), 16'(got.precede_pad));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_bus_step(in_user_i, in_data_i, want);
        bus_step_q.push_back(want);
      end
      outstanding_cnt = bus_step_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top: stimulus and verdict for the SMBus word master sequencer.
`timescale 1ns / 100ps
module tb;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [smbus_wm_pkg::InDataW-1:0]    s_axis_tdata;
  logic                                s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [smbus_wm_pkg::OutDataW-1:0]   m_axis_tdata;

  int mismatches;
  int outstanding;
  int n_items;
  int n_begins;
  int n_events;
  bit sender_idles;

  smbus_word_master_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  smbus_wm_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .in_user_i     (s_axis_tuser),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_i    (m_axis_tdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a hung run
  initial begin
    #1ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [smbus_wm_pkg::InDataW-1:0] rand_bits();
    return {8'($urandom_range(255)), 32'($urandom)};
  endfunction

  function automatic logic [smbus_wm_pkg::InDataW-1:0] begin_word(
      input logic rd, input logic [6:0] addr, input logic [7:0] cmd,
      input logic [7:0] lo, input logic [7:0] hi, input logic [7:0] rx);
    return {rx, hi, lo, cmd, addr, rd};
  endfunction

  // Received byte on top, noise in the fields an event ignores
  function automatic logic [smbus_wm_pkg::InDataW-1:0] event_word(input logic [7:0] rx);
    logic [smbus_wm_pkg::InDataW-1:0] w;
    w = rand_bits();
    w[39:32] = rx;
    return w;
  endfunction

  // Offer one item after an optional random gap; return at the falling edge after acceptance
  task automatic offer(input logic op, input logic [smbus_wm_pkg::InDataW-1:0] d);
    while (sender_idles && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    n_items++;
    if (op == smbus_wm_pkg::OP_BEGIN) n_begins++;
    else n_events++;
  endtask

  // Hold the sender until every predicted bus step has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off and one stretch with no stalls
  initial begin : receiver
    int ready_cycle;
    ready_cycle   = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      ready_cycle++;
      if (ready_cycle == 700) begin
        m_axis_tready <= 1'b0;
        repeat (80) @(negedge clk_i);
      end else if (ready_cycle >= 1200 && ready_cycle < 1500) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 23);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int pick;
    int steps;
    int n_ev;
    logic rd;
    bit paused;
    n_items       = 0;
    n_begins      = 0;
    n_events      = 0;
    sender_idles  = 1'b1;
    paused        = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = smbus_wm_pkg::OP_BEGIN;
    s_axis_tdata  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Event while idle after reset: no action, nothing changes
    offer(smbus_wm_pkg::OP_EVENT, event_word(8'hA5));
    // Full write word with extreme operands, then events held at the done phase
    offer(smbus_wm_pkg::OP_BEGIN, begin_word(1'b0, 7'h7F, 8'hFF, 8'h00, 8'hFF, 8'h00));
    repeat (7) offer(smbus_wm_pkg::OP_EVENT, event_word(8'hFF));
    // Full read word: low byte all ones, high byte all zeros, then done
    offer(smbus_wm_pkg::OP_BEGIN, begin_word(1'b1, 7'h00, 8'h00, 8'hFF, 8'h00, 8'hFF));
    for (int k = 0; k < 10; k++)
      offer(smbus_wm_pkg::OP_EVENT, event_word(k == 5 ? 8'hFF : 8'h00));
    // Begin while busy restarts with the new direction and operands
    offer(smbus_wm_pkg::OP_BEGIN, begin_word(1'b1, 7'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
    repeat (2) offer(smbus_wm_pkg::OP_EVENT, event_word(8'h3C));
    offer(smbus_wm_pkg::OP_BEGIN, begin_word(1'b0, 7'h2A, 8'h55, 8'hAA, 8'h55, 8'hAA));
    offer(smbus_wm_pkg::OP_EVENT, event_word(8'hC3));
    drain();

    // Random part: mostly well-formed word transactions, some cut short, some noise
    while (n_items < 1275) begin
      sender_idles = !(n_items >= 400 && n_items < 600);
      if (!paused && n_items >= 900) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 4)) offer(1'($urandom_range(1)), rand_bits());
      end else begin
        rd = 1'($urandom_range(1));
        offer(smbus_wm_pkg::OP_BEGIN,
              begin_word(rd, 7'($urandom_range(127)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255))));
        steps = rd ? 9 : 5;
        if (pick < 25) n_ev = $urandom_range(steps - 1);
        else n_ev = steps + $urandom_range(1, 3);
        repeat (n_ev) offer(smbus_wm_pkg::OP_EVENT, event_word(8'($urandom_range(255))));
      end
    end
    s_axis_tvalid <= 1'b0;

    // Wait out the remaining bus steps and the result register
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    $display("Sent %0d items (%0d begins, %0d bus step events): full and cut-short read",
             n_items, n_begins, n_events);
    $display("and write word sequences, restarts, idle and done events, output back-pressure.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ smbus_word_master_sequencer.f @@
design/smbus_wm_pkg.sv
design/smbus_word_master_sequencer.sv
tb/smbus_wm_checker.sv
tb/tb.sv
